// ===== hw/rtl/lrust_pkg.sv =====
// ----------------------------------------------------------------------------
// lrust_pkg
// Shared types and constants of the LRU page stack tracker: request and
// response payloads, action codes and default sizes.
// ----------------------------------------------------------------------------
package lrust_pkg;

  // field widths fixed by the interface
  localparam int unsigned PageBits  = 52;
  localparam int unsigned DepthBits = 4;
  localparam int unsigned OccBits   = 5;
  localparam int unsigned CapBits   = 5;

  // default stack size and capacity after reset
  localparam int unsigned        StackDepth = 16;
  localparam logic [CapBits-1:0] CapReset   = 5'd16;

  // request action codes
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_SEEK = 1'b1
  } action_e;

  // one request
  typedef struct packed {
    action_e               action;
    logic [PageBits-1:0]   page_number;
  } in_req_t;

  // one response
  typedef struct packed {
    logic                  found;
    logic [DepthBits-1:0]  depth;
    logic                  evicted;
    logic [PageBits-1:0]   evicted_page;
    logic [OccBits-1:0]    occupancy;
  } out_rsp_t;

endpackage

// ===== hw/rtl/lrust_ram.sv =====
// ----------------------------------------------------------------------------
// lrust_ram
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lrust_ram #(
  parameter int unsigned DEPTH = lrust_pkg::StackDepth,
  parameter int unsigned WIDTH = lrust_pkg::PageBits,
  parameter int unsigned ADDRW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ADDRW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [ADDRW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lru_stack_page_tracker.sv =====
// Throughput: one request at a time; the stack sits in a ring buffer in one
//   memory and a seek walks it one entry per cycle through the read port.
// Reset: stack empty, capacity 16, no response pending; memory contents are
//   left as they are, only entries below the count are ever read.
// ----------------------------------------------------------------------------
// lru_stack_page_tracker
// Recency-ordered page stack with eviction on push, and stack distance
// reporting and removal of the page found on seek.
// ----------------------------------------------------------------------------
module lru_stack_page_tracker #(
  parameter int unsigned STACK_DEPTH = lrust_pkg::StackDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lrust_pkg::CapBits-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lrust_pkg::in_req_t            in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lrust_pkg::out_rsp_t           out_rsp_o
);

  import lrust_pkg::*;

  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW = IW + 1;
  localparam int unsigned EW = (CW > CapBits) ? CW : CapBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [IW-1:0]         head_q;
  logic [CW-1:0]         count_q;
  logic [CW-1:0]         pos_q;
  logic [CapBits-1:0]    cap_q;
  in_req_t               req_q;
  logic                  found_q;
  logic [CW-1:0]         depth_q;
  logic                  evicted_q;
  logic [PageBits-1:0]   evict_page_q;
  logic                  out_valid_q;
  out_rsp_t              out_q;

  logic [EW-1:0]         cap_ext;
  logic [CW-1:0]         ecap;
  logic                  full;
  logic                  in_fire;
  logic                  hit;
  logic                  last;
  logic [IW-1:0]         head_dec;
  logic [IW-1:0]         head_inc;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [PageBits-1:0]   rd_data;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [PageBits-1:0]   wr_data;

  // stack position to ring buffer address
  function automatic logic [IW-1:0] phys_idx(input logic [IW-1:0] head,
                                             input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(pos);
    if (sum >= SW'(STACK_DEPTH)) begin
      sum = sum - SW'(STACK_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // effective capacity, clamped to one up to the stack depth
  always_comb begin
    cap_ext = EW'(cap_q);
    if (cap_q == '0) begin
      ecap = CW'(1);
    end else if (cap_ext > EW'(STACK_DEPTH)) begin
      ecap = CW'(STACK_DEPTH);
    end else begin
      ecap = CW'(cap_ext);
    end
  end

  // head pointer moves with wrap
  assign head_dec = (head_q == '0) ? IW'(STACK_DEPTH - 1) : IW'(head_q - 1'b1);
  assign head_inc = (head_q == IW'(STACK_DEPTH - 1)) ? '0 : IW'(head_q + 1'b1);

  assign full    = (count_q >= ecap);
  assign in_fire = in_valid_i && in_ready_o;
  assign hit     = (rd_data == req_q.page_number);
  assign last    = (CW'(pos_q + 1'b1) == count_q);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = phys_idx(head_q, pos_q);
    wr_en   = 1'b0;
    wr_addr = head_dec;
    wr_data = req_q.page_number;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_i.action == ACT_PUSH) begin
            if (full) begin
              rd_en   = 1'b1;
              rd_addr = phys_idx(head_q, CW'(ecap - 1'b1));
            end else begin
              wr_en   = 1'b1;
              wr_data = in_req_i.page_number;
            end
          end else if (count_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = phys_idx(head_q, '0);
          end
        end
      end
      ST_EVICT: begin
        wr_en = 1'b1;
      end
      ST_SCAN: begin
        if (hit) begin
          if (pos_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = phys_idx(head_q, CW'(pos_q - 1'b1));
          end
        end else if (!last) begin
          rd_en   = 1'b1;
          rd_addr = phys_idx(head_q, CW'(pos_q + 1'b1));
        end
      end
      ST_SHIFT: begin
        // move the entry just read one place down
        wr_en   = 1'b1;
        wr_addr = phys_idx(head_q, CW'(pos_q + 1'b1));
        wr_data = rd_data;
        if (pos_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = phys_idx(head_q, CW'(pos_q - 1'b1));
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // stack storage
  lrust_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (PageBits),
    .ADDRW (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // sequencer, configuration and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      pos_q        <= '0;
      cap_q        <= CapReset;
      req_q        <= '0;
      found_q      <= 1'b0;
      depth_q      <= '0;
      evicted_q    <= 1'b0;
      evict_page_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      // response taken and no new one loaded this cycle
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            req_q        <= in_req_i;
            found_q      <= 1'b0;
            depth_q      <= '0;
            evicted_q    <= 1'b0;
            evict_page_q <= '0;
            pos_q        <= '0;
            if (in_req_i.action == ACT_PUSH) begin
              if (full) begin
                state_q <= ST_EVICT;
              end else begin
                head_q  <= head_dec;
                count_q <= CW'(count_q + 1'b1);
                state_q <= ST_DONE;
              end
            end else if (count_q == '0) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_EVICT: begin
          evicted_q    <= 1'b1;
          evict_page_q <= rd_data;
          head_q       <= head_dec;
          count_q      <= ecap;
          state_q      <= ST_DONE;
        end
        ST_SCAN: begin
          if (hit) begin
            found_q <= 1'b1;
            depth_q <= pos_q;
            if (pos_q == '0) begin
              head_q  <= head_inc;
              count_q <= CW'(count_q - 1'b1);
              state_q <= ST_DONE;
            end else begin
              pos_q   <= CW'(pos_q - 1'b1);
              state_q <= ST_SHIFT;
            end
          end else if (last) begin
            state_q <= ST_DONE;
          end else begin
            pos_q <= CW'(pos_q + 1'b1);
          end
        end
        ST_SHIFT: begin
          if (pos_q == '0) begin
            head_q  <= head_inc;
            count_q <= CW'(count_q - 1'b1);
            state_q <= ST_DONE;
          end else begin
            pos_q <= CW'(pos_q - 1'b1);
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.found        <= found_q;
            out_q.depth        <= DepthBits'(depth_q);
            out_q.evicted      <= evicted_q;
            out_q.evicted_page <= evict_page_q;
            out_q.occupancy    <= OccBits'(count_q);
            out_valid_q        <= 1'b1;
            state_q            <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== hw/rtl/lrust_checker.sv =====
// ----------------------------------------------------------------------------
// lrust_checker
// Port level checks of the LRU page stack tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lrust_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input lrust_pkg::out_rsp_t out_rsp_i
);

  import lrust_pkg::*;

  // a response waiting for the sink holds its value
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rsp_i))
    else $error("response changed while stalled");

  // the block is busy in the cycle after it takes a request
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one still in progress");

  // a fresh response only comes out of a busy cycle
  a_rsp_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("response appeared without a request in progress");

endmodule

bind lru_stack_page_tracker lrust_checker u_lrust_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_i   (out_rsp_o)
);
